// File: rtl/ipow_pkg.sv
`default_nettype none

package ipow_pkg;

  // Fixed width of the base, exponent and power fields on the ports.
  localparam int unsigned FieldW = 64;

  // Default operating width of the arithmetic.
  localparam int unsigned DefDataWidth = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOP,
    ST_MUL,
    ST_COMMIT,
    ST_FINISH
  } state_e;

  // Where the product of the shared multiplier goes once it is complete.
  typedef enum logic [1:0] {
    TGT_ODD,
    TGT_EVEN,
    TGT_FINAL
  } mul_tgt_e;

endpackage

`default_nettype wire

// File: rtl/integer_power_by_squaring.sv
// Integer power by repeated squaring: power = base ** exponent mod 2^DATA_WIDTH.
// Input channel: base_i and exponent_i move in one transaction when
// in_valid_i is high and in_stall_o is low. Only the low DATA_WIDTH bits of
// each field are used. in_stall_o stays high for the whole time one
// transaction is being worked on.
// Output channel: power_o and overflow_o move when out_valid_o is high and
// out_stall_i is low. overflow_o is set when any multiplication (the final
// odd-times-even product included) had an exact product wider than
// DATA_WIDTH bits; power_o always carries the wrapped low bits.
// Sequence: with a zero exponent the block goes straight from the accept to
// the finish state. Otherwise each pass of the squaring loop runs the loop
// state and then, per multiplication, 4 partial products through one shared
// half-width multiplier, one accumulate tail and one commit; the final
// product takes the same steps, and the finish state follows it.
// Throughput: one transaction at a time; the next one is taken as soon as
// the result is parked in the output register, even if it is still stalled.
// A stalled result holds; the block waits in its finish state if a new
// result is ready while the old one is still stalled.
// Reset clears the sequencer and the output valid; a transaction in progress
// is lost, and no result is produced by reset.
`default_nettype none

module integer_power_by_squaring #(
  parameter int unsigned DATA_WIDTH = ipow_pkg::DefDataWidth
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire logic [ipow_pkg::FieldW-1:0] base_i,
  input  wire logic [ipow_pkg::FieldW-1:0] exponent_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      logic [ipow_pkg::FieldW-1:0] power_o,
  output      logic                        overflow_o
);

  // Operands are split in two halves; each half goes through the shared
  // HalfW x HalfW multiplier.
  localparam int unsigned HalfW = (DATA_WIDTH + 1) / 2;
  localparam int unsigned ExtW  = 2 * HalfW;
  localparam int unsigned ProdW = 4 * HalfW;

  ipow_pkg::state_e   state_q, state_d;
  ipow_pkg::mul_tgt_e tgt_q, tgt_d;
  logic [2:0]         cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;

  logic [DATA_WIDTH-1:0] e_q, e_d;
  logic [DATA_WIDTH-1:0] odd_q, odd_d;
  logic [DATA_WIDTH-1:0] even_q, even_d;
  logic [DATA_WIDTH-1:0] ma_q, ma_d;
  logic [DATA_WIDTH-1:0] mb_q, mb_d;
  logic [DATA_WIDTH-1:0] res_q, res_d;
  logic [DATA_WIDTH-1:0] power_q, power_d;
  logic                  ov_q, ov_d;
  logic                  ovf_out_q, ovf_out_d;
  logic [ExtW-1:0]       pp_q, pp_d;
  logic [1:0]            pp_sh_q, pp_sh_d;
  logic [ProdW-1:0]      acc_q, acc_d;

  logic                  in_fire;
  logic                  out_fire;
  logic [ExtW-1:0]       ma_ext, mb_ext;
  logic [HalfW-1:0]      a_part, b_part;
  logic [ProdW-1:0]      pp_ext, pp_shifted;
  logic [DATA_WIDTH-1:0] prod_lo;
  logic                  prod_ovf;

  assign in_stall_o  = (state_q != ipow_pkg::ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_fire    = out_valid_q && !out_stall_i;
  assign power_o     = ipow_pkg::FieldW'(power_q);
  assign overflow_o  = ovf_out_q;

  // Shared multiplier datapath: partial product select and shift.
  assign ma_ext = ExtW'(ma_q);
  assign mb_ext = ExtW'(mb_q);
  assign a_part = cnt_q[1] ? ma_ext[ExtW-1:HalfW] : ma_ext[HalfW-1:0];
  assign b_part = cnt_q[0] ? mb_ext[ExtW-1:HalfW] : mb_ext[HalfW-1:0];
  assign pp_ext = ProdW'(pp_q);

  always_comb begin
    case (pp_sh_q)
      2'd0:    pp_shifted = pp_ext;
      2'd1:    pp_shifted = pp_ext << HalfW;
      default: pp_shifted = pp_ext << (2 * HalfW);
    endcase
  end

  assign prod_lo  = acc_q[DATA_WIDTH-1:0];
  assign prod_ovf = |acc_q[ProdW-1:DATA_WIDTH];

  always_comb begin
    state_d     = state_q;
    tgt_d       = tgt_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    e_d         = e_q;
    odd_d       = odd_q;
    even_d      = even_q;
    ma_d        = ma_q;
    mb_d        = mb_q;
    res_d       = res_q;
    power_d     = power_q;
    ov_d        = ov_q;
    ovf_out_d   = ovf_out_q;
    pp_d        = pp_q;
    pp_sh_d     = pp_sh_q;
    acc_d       = acc_q;

    if (out_fire) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ipow_pkg::ST_IDLE: begin
        if (in_fire) begin
          e_d    = exponent_i[DATA_WIDTH-1:0];
          odd_d  = DATA_WIDTH'(1);
          even_d = base_i[DATA_WIDTH-1:0];
          ov_d   = 1'b0;
          if (exponent_i[DATA_WIDTH-1:0] == '0) begin
            res_d   = DATA_WIDTH'(1);
            state_d = ipow_pkg::ST_FINISH;
          end else begin
            state_d = ipow_pkg::ST_LOOP;
          end
        end
      end

      ipow_pkg::ST_LOOP: begin
        // Pick the next multiplication of the square-and-multiply loop.
        cnt_d   = '0;
        acc_d   = '0;
        state_d = ipow_pkg::ST_MUL;
        if (e_q == DATA_WIDTH'(1)) begin
          ma_d  = odd_q;
          mb_d  = even_q;
          tgt_d = ipow_pkg::TGT_FINAL;
        end else if (e_q[0]) begin
          ma_d  = odd_q;
          mb_d  = even_q;
          tgt_d = ipow_pkg::TGT_ODD;
        end else begin
          ma_d  = even_q;
          mb_d  = even_q;
          tgt_d = ipow_pkg::TGT_EVEN;
        end
      end

      ipow_pkg::ST_MUL: begin
        // Steps 0..3 form a partial product; steps 1..4 add the previous one.
        if (cnt_q != 3'd4) begin
          pp_d    = ExtW'(a_part) * ExtW'(b_part);
          pp_sh_d = {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
        end
        if (cnt_q != 3'd0) begin
          acc_d = acc_q + pp_shifted;
        end
        if (cnt_q == 3'd4) begin
          state_d = ipow_pkg::ST_COMMIT;
        end
        cnt_d = cnt_q + 3'd1;
      end

      ipow_pkg::ST_COMMIT: begin
        ov_d = ov_q | prod_ovf;
        unique case (tgt_q)
          ipow_pkg::TGT_ODD: begin
            // Odd step: fold in, drop the low bit, then square right away.
            odd_d   = prod_lo;
            e_d     = {e_q[DATA_WIDTH-1:1], 1'b0};
            ma_d    = even_q;
            mb_d    = even_q;
            tgt_d   = ipow_pkg::TGT_EVEN;
            cnt_d   = '0;
            acc_d   = '0;
            state_d = ipow_pkg::ST_MUL;
          end
          ipow_pkg::TGT_EVEN: begin
            even_d  = prod_lo;
            e_d     = e_q >> 1;
            state_d = ipow_pkg::ST_LOOP;
          end
          default: begin
            res_d   = prod_lo;
            state_d = ipow_pkg::ST_FINISH;
          end
        endcase
      end

      ipow_pkg::ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          power_d     = res_q;
          ovf_out_d   = ov_q;
          out_valid_d = 1'b1;
          state_d     = ipow_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = ipow_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ipow_pkg::ST_IDLE;
      tgt_q       <= ipow_pkg::TGT_ODD;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tgt_q       <= tgt_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q       <= e_d;
    odd_q     <= odd_d;
    even_q    <= even_d;
    ma_q      <= ma_d;
    mb_q      <= mb_d;
    res_q     <= res_d;
    power_q   <= power_d;
    ov_q      <= ov_d;
    ovf_out_q <= ovf_out_d;
    pp_q      <= pp_d;
    pp_sh_q   <= pp_sh_d;
    acc_q     <= acc_d;
  end

  // The multiply step counter never runs past its accumulate tail.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ipow_pkg::ST_MUL |-> cnt_q <= 3'd4)
    else $error("multiply step counter out of range");

  // The loop is never entered with a spent exponent.
  a_loop_exp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ipow_pkg::ST_LOOP |-> e_q != '0)
    else $error("loop pass with zero exponent");

  // A squaring is only committed on an even exponent.
  a_even_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ipow_pkg::ST_COMMIT && tgt_q == ipow_pkg::TGT_EVEN) |-> !e_q[0])
    else $error("squaring committed on odd exponent");

  // An accepted transaction blocks the input on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o)
    else $error("input not stalled after accept");

  // A new result only appears out of the finish state.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ipow_pkg::ST_FINISH))
    else $error("result raised outside finish state");

endmodule

`default_nettype wire
